FILE: hdl/mres_pkg.sv
package mres_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int ENERGY_W    = 38;
   localparam int GAIN_W      = 6;
   localparam int UNIF_W      = 16;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int DELTA_W     = 41;

   // shared multiplier operand widths
   localparam int MUL_A_W = 38;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // exp arithmetic in Q1.30
   localparam int Q_SHIFT = 30;
   localparam int Q_W     = Q_SHIFT + 1;
   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_SHIFT;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WELL_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTNER_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SAMPLE = 2'd2;

   localparam logic FUNC_WALK = 1'b0;
   localparam logic FUNC_SWAP = 1'b1;

   localparam logic [GAIN_W-1:0]          WELL_GAIN_RESET    = 6'd1;
   localparam logic [GAIN_W-1:0]          PARTNER_GAIN_RESET = 6'd21;
   localparam logic signed [SAMPLE_W-1:0] START_SAMPLE_RESET = -24'sd1048576;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_E_SQ, S_E_D2, S_E_GAIN, S_X_START, S_X_MUL,
      S_X_DIV, S_X_FIX, S_X_CLAMP, S_X_SQR, S_X_CMP, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      J_RECALC, J_PRIME, J_WALK, J_SW0, J_SW1, J_SW2, J_SW3
   } job_type;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] step_noise;
      logic [UNIF_W-1:0]          uniform_draw;
      logic signed [SAMPLE_W-1:0] partner_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [ENERGY_W-1:0]        energy_out;
      logic                       move_accepted;
      logic signed [SAMPLE_W-1:0] returned_sample;
      logic [COUNT_W-1:0]         walk_accepts;
      logic [COUNT_W-1:0]         swap_accepts;
   } rsp_type;

endpackage

FILE: hdl/mres_mul.sv
module mres_mul
   import mres_pkg::*;
(
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] p
);

   assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

FILE: hdl/metropolis_replica_exchange_step.sv
// Channel  Direction  Handshake              Word
// req      in         req_valid/req_ready    req_data  (func, noise, draw, partner)
// rsp      out        rsp_valid/rsp_ready    rsp_data  (sample, energy, flags, counts)
// csr      in         csr_wr_en              csr_index, csr_wdata
//
// One word at a time through a sequencer around one shared multiplier.
// A walk computes one energy, runs the series, then returns to idle before the
// next word; an exchange computes three more energies; the first word after
// reset also primes the held energy. A non-negative exponent, or a negative
// one of magnitude 16 or more, skips the series. Each series term takes three
// multiplier passes (product, reciprocal, remainder).
// Reset clears control and counts and loads the default configuration; a
// result waits in the output register, and only a finished word stalls on rsp_ready.
module metropolis_replica_exchange_step
   import mres_pkg::*;
#(
   parameter int FRAC_BITS = 20,
   parameter int EXP_TERMS = 6
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int KW = $clog2(EXP_TERMS);
   localparam logic [KW-1:0] K_LAST = KW'(EXP_TERMS - 1);
   localparam logic signed [48:0] ONE_E = 49'sd1 <<< FRAC_BITS;
   localparam logic [DELTA_W-1:0] A_LIMIT = DELTA_W'(16) << FRAC_BITS;
   localparam int RECIP_SHIFT = 32;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic primed_ff, primed_in, recalc_ff, recalc_in;
   logic [GAIN_W-1:0] well_ff, well_in, partner_ff, partner_in, eg_ff, eg_in;
   logic signed [SAMPLE_W-1:0] start_ff, start_in, pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0] prop_ff, prop_in, ex_ff, ex_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in, enew_ff, enew_in, d2_ff, d2_in;
   logic [COUNT_W-1:0] walk_ff, walk_in, swap_ff, swap_in;
   req_type item_ff, item_in;
   logic [31:0] ad_ff, ad_in;
   logic esat_ff, esat_in, ok_ff, ok_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [Q_SHIFT-1:0] t_ff, t_in;
   logic [Q_W-1:0] term_ff, term_in, num_ff, num_in, p_ff, p_in;
   logic signed [Q_W+1:0] sum_ff, sum_in;
   logic [KW-1:0] k_ff, k_in;
   logic [1:0] sq_cnt_ff, sq_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;

   mres_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

   // floor(2^32 / k) for the series divisors, a small constant table
   function automatic logic [RECIP_SHIFT:0] recip(input logic [KW-1:0] k);
      logic [RECIP_SHIFT:0] r;
      r = '0;
      for (int i = 1; i < EXP_TERMS; i++) begin
         if (k == KW'(i)) begin
            r = (RECIP_SHIFT+1)'((64'd1 << RECIP_SHIFT) / 64'(i));
         end
      end
      return r;
   endfunction

   logic [SAMPLE_W-1:0] ax;
   logic [47:0] sq48;
   logic signed [48:0] dd;
   logic [48:0] ad49;
   logic [63:0] d2_64;
   logic [ENERGY_W-1:0] e_val;
   logic signed [SAMPLE_W:0] prop_sum;
   logic [DELTA_W-1:0] a_mag;
   logic [71:0] t_wide;
   logic [Q_W-1:0] q_rem;
   logic [Q_W-1:0] quo;

   assign ax       = ex_ff[SAMPLE_W-1] ? SAMPLE_W'(-ex_ff) : SAMPLE_W'(ex_ff);
   assign sq48     = 48'(mul_p >> FRAC_BITS);
   assign dd       = $signed({1'b0, sq48}) - ONE_E;
   assign ad49     = dd[48] ? 49'(-dd) : 49'(dd);
   assign d2_64    = 64'(mul_p >> FRAC_BITS);
   assign prop_sum = (SAMPLE_W+1)'(pos_ff) + (SAMPLE_W+1)'(item_ff.step_noise);
   assign a_mag    = DELTA_W'(-delta_ff);
   assign t_wide   = (72'(a_mag) << Q_SHIFT) >> (FRAC_BITS + 4);
   // the reciprocal estimate is at most one short; the remainder tells
   assign q_rem    = num_ff - mul_p[Q_W-1:0];
   assign quo      = (q_rem >= Q_W'(k_ff)) ? term_ff + Q_W'(1) : term_ff;

   // zero gain gives zero; any overflow along the way saturates
   always_comb begin
      if (eg_ff == '0) begin
         e_val = '0;
      end else if (esat_ff || (|mul_p[MUL_P_W-1:ENERGY_W])) begin
         e_val = ENERGY_MAX;
      end else begin
         e_val = mul_p[ENERGY_W-1:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_E_SQ: begin
            mul_a = MUL_A_W'(ax);
            mul_b = MUL_B_W'(ax);
         end
         S_E_D2: begin
            mul_a = MUL_A_W'(ad_ff);
            mul_b = ad_ff;
         end
         S_E_GAIN: begin
            mul_a = d2_ff;
            mul_b = MUL_B_W'(eg_ff);
         end
         S_X_MUL: begin
            mul_a = MUL_A_W'(term_ff);
            mul_b = MUL_B_W'(t_ff);
         end
         S_X_DIV: begin
            mul_a = MUL_A_W'(recip(k_ff));
            mul_b = MUL_B_W'(num_ff);
         end
         S_X_FIX: begin
            mul_a = MUL_A_W'(term_ff);
            mul_b = MUL_B_W'(k_ff);
         end
         S_X_SQR: begin
            mul_a = MUL_A_W'(p_ff);
            mul_b = MUL_B_W'(p_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      primed_in    = primed_ff;
      recalc_in    = recalc_ff;
      well_in      = well_ff;
      partner_in   = partner_ff;
      start_in     = start_ff;
      pos_in       = pos_ff;
      prop_in      = prop_ff;
      ex_in        = ex_ff;
      eg_in        = eg_ff;
      energy_in    = energy_ff;
      enew_in      = enew_ff;
      d2_in        = d2_ff;
      walk_in      = walk_ff;
      swap_in      = swap_ff;
      item_in      = item_ff;
      ad_in        = ad_ff;
      esat_in      = esat_ff;
      ok_in        = ok_ff;
      delta_in     = delta_ff;
      t_in         = t_ff;
      term_in      = term_ff;
      num_in       = num_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      sq_cnt_in    = sq_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = (state_ff == S_IDLE) && !recalc_ff && !csr_wr_en;

      case (state_ff)
         S_IDLE: begin
            if (recalc_ff) begin
               // refresh the held energy after a gain change
               ex_in    = pos_ff;
               eg_in    = well_ff;
               job_in   = J_RECALC;
               state_in = S_E_SQ;
            end else if (req_valid && req_ready) begin
               item_in  = req_data;
               state_in = S_PREP;
               if (!primed_ff) begin
                  pos_in = start_ff;
               end
            end
         end
         S_PREP: begin
            eg_in    = well_ff;
            state_in = S_E_SQ;
            if (!primed_ff) begin
               ex_in  = pos_ff;
               job_in = J_PRIME;
            end else if (item_ff.func == FUNC_WALK) begin
               // saturate the proposal to the sample range
               if (prop_sum[SAMPLE_W] != prop_sum[SAMPLE_W-1]) begin
                  prop_in = prop_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_W-1){1'b1}}};
               end else begin
                  prop_in = prop_sum[SAMPLE_W-1:0];
               end
               ex_in  = prop_in;
               job_in = J_WALK;
            end else begin
               ex_in  = pos_ff;
               job_in = J_SW0;
            end
         end
         S_E_SQ: begin
            ad_in    = ad49[31:0];
            esat_in  = |ad49[48:32];
            state_in = S_E_D2;
         end
         S_E_D2: begin
            d2_in    = d2_64[ENERGY_W-1:0];
            esat_in  = esat_ff | (|d2_64[63:ENERGY_W]);
            state_in = S_E_GAIN;
         end
         S_E_GAIN: begin
            state_in = S_E_SQ;
            case (job_ff)
               J_RECALC: begin
                  energy_in = e_val;
                  recalc_in = 1'b0;
                  state_in  = S_IDLE;
               end
               J_PRIME: begin
                  energy_in = e_val;
                  primed_in = 1'b1;
                  state_in  = S_PREP;
               end
               J_WALK: begin
                  enew_in  = e_val;
                  delta_in = $signed(DELTA_W'(energy_ff)) - $signed(DELTA_W'(e_val));
                  state_in = S_X_START;
               end
               J_SW0: begin
                  delta_in = $signed(DELTA_W'(e_val));
                  ex_in    = item_ff.partner_sample;
                  eg_in    = partner_ff;
                  job_in   = J_SW1;
               end
               J_SW1: begin
                  delta_in = delta_ff + $signed(DELTA_W'(e_val));
                  ex_in    = item_ff.partner_sample;
                  eg_in    = well_ff;
                  job_in   = J_SW2;
               end
               J_SW2: begin
                  delta_in = delta_ff - $signed(DELTA_W'(e_val));
                  enew_in  = e_val;
                  ex_in    = pos_ff;
                  eg_in    = partner_ff;
                  job_in   = J_SW3;
               end
               J_SW3: begin
                  delta_in = delta_ff - $signed(DELTA_W'(e_val));
                  state_in = S_X_START;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_X_START: begin
            if (!delta_ff[DELTA_W-1]) begin
               ok_in    = 1'b1;
               state_in = S_FINISH;
            end else if (a_mag >= A_LIMIT) begin
               ok_in    = 1'b0;
               state_in = S_FINISH;
            end else begin
               t_in     = t_wide[Q_SHIFT-1:0];
               term_in  = Q_ONE;
               sum_in   = $signed((Q_W+2)'(Q_ONE));
               k_in     = KW'(1);
               state_in = S_X_MUL;
            end
         end
         S_X_MUL: begin
            num_in   = Q_W'(mul_p >> Q_SHIFT);
            state_in = S_X_DIV;
         end
         S_X_DIV: begin
            // quotient estimate by reciprocal multiply
            term_in  = Q_W'(mul_p >> RECIP_SHIFT);
            state_in = S_X_FIX;
         end
         S_X_FIX: begin
            term_in  = quo;
            sum_in   = k_ff[0] ? sum_ff - $signed({2'b00, quo})
                               : sum_ff + $signed({2'b00, quo});
            k_in     = k_ff + KW'(1);
            state_in = (k_ff == K_LAST) ? S_X_CLAMP : S_X_MUL;
         end
         S_X_CLAMP: begin
            if (sum_ff[Q_W+1]) begin
               p_in = '0;
            end else if (sum_ff > $signed((Q_W+2)'(Q_ONE))) begin
               p_in = Q_ONE;
            end else begin
               p_in = sum_ff[Q_W-1:0];
            end
            sq_cnt_in = '0;
            state_in  = S_X_SQR;
         end
         S_X_SQR: begin
            p_in      = Q_W'(mul_p >> Q_SHIFT);
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd3) begin
               state_in = S_X_CMP;
            end
         end
         S_X_CMP: begin
            ok_in    = p_ff > Q_W'({item_ff.uniform_draw, 14'b0});
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.returned_sample = '0;
               if (item_ff.func == FUNC_WALK) begin
                  if (ok_ff) begin
                     pos_in    = prop_ff;
                     energy_in = enew_ff;
                     walk_in   = walk_ff + COUNT_W'(1);
                  end
               end else begin
                  rsp_in.returned_sample = ok_ff ? pos_ff : item_ff.partner_sample;
                  if (ok_ff) begin
                     pos_in    = item_ff.partner_sample;
                     energy_in = enew_ff;
                     swap_in   = swap_ff + COUNT_W'(1);
                  end
               end
               rsp_in.sample_out    = pos_in;
               rsp_in.energy_out    = energy_in;
               rsp_in.move_accepted = ok_ff;
               rsp_in.walk_accepts  = walk_in;
               rsp_in.swap_accepts  = swap_in;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration writes; unknown indexes drop
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WELL_GAIN: begin
               well_in = csr_wdata[GAIN_W-1:0];
               if (primed_ff) begin
                  recalc_in = 1'b1;
               end
            end
            CSR_PARTNER_GAIN: begin
               partner_in = csr_wdata[GAIN_W-1:0];
            end
            CSR_START_SAMPLE: begin
               start_in = $signed(csr_wdata[SAMPLE_W-1:0]);
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= J_RECALC;
         primed_ff    <= 1'b0;
         recalc_ff    <= 1'b0;
         well_ff      <= WELL_GAIN_RESET;
         partner_ff   <= PARTNER_GAIN_RESET;
         start_ff     <= START_SAMPLE_RESET;
         walk_ff      <= '0;
         swap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         primed_ff    <= primed_in;
         recalc_ff    <= recalc_in;
         well_ff      <= well_in;
         partner_ff   <= partner_in;
         start_ff     <= start_in;
         walk_ff      <= walk_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      prop_ff    <= prop_in;
      ex_ff      <= ex_in;
      eg_ff      <= eg_in;
      energy_ff  <= energy_in;
      enew_ff    <= enew_in;
      d2_ff      <= d2_in;
      item_ff    <= item_in;
      ad_ff      <= ad_in;
      esat_ff    <= esat_in;
      ok_ff      <= ok_in;
      delta_ff   <= delta_in;
      t_ff       <= t_in;
      term_ff    <= term_in;
      num_ff     <= num_in;
      p_ff       <= p_in;
      sum_ff     <= sum_in;
      k_ff       <= k_in;
      sq_cnt_ff  <= sq_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted word always starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_PREP))
      else $error("accepted word did not start the sequencer");

   // counters move only when a result is issued
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> ($stable(walk_ff) && $stable(swap_ff)))
      else $error("acceptance count changed outside result issue");

   // squaring runs on a clamped probability
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_X_SQR) |-> (p_ff <= Q_ONE))
      else $error("probability above one during squaring");
`endif

endmodule

FILE: dv/testbench.sv
`default_nettype none

// Bit-level predictor and in-order store of expected results for the chain.
class chain_scoreboard;
   localparam int FRAC  = 20;
   localparam int TERMS = 6;
   localparam longint signed SMAX = 8388607;
   localparam longint signed SMIN = -8388608;
   localparam longint unsigned EMAX = 64'h3F_FFFF_FFFF;
   localparam longint unsigned QONE = 64'd1 << 30;

   // mirrored configuration
   longint unsigned well_g;
   longint unsigned partner_g;
   longint signed   start_pos;
   // mirrored chain state
   longint signed   cur_pos;
   longint unsigned cur_energy;
   int unsigned     walk_cnt;
   int unsigned     swap_cnt;
   bit              primed;

   mres_pkg::rsp_type expected_q[$];
   int unsigned       errors;
   int unsigned       words_seen;
   int unsigned       walks_in;
   int unsigned       swaps_in;

   function new();
      well_g     = 1;
      partner_g  = 21;
      start_pos  = -1048576;
      cur_pos    = 0;
      cur_energy = 0;
      walk_cnt   = 0;
      swap_cnt   = 0;
      primed     = 0;
      errors     = 0;
      words_seen = 0;
      walks_in   = 0;
      swaps_in   = 0;
   endfunction

   function automatic longint unsigned well_energy(longint signed x, longint unsigned g);
      longint unsigned ax, sq, ad, d2, e;
      longint signed   d;
      if (g == 0) return 0;
      ax = (x < 0) ? longint'(-x) : longint'(x);
      sq = (ax * ax) >> FRAC;
      d  = longint'(sq) - (longint'(1) << FRAC);
      ad = (d < 0) ? longint'(-d) : longint'(d);
      if (ad > 64'hFFFF_FFFF) return EMAX;
      d2 = (ad * ad) >> FRAC;
      if (d2 > EMAX) return EMAX;
      e = g * d2;
      return (e > EMAX) ? EMAX : e;
   endfunction

   // exp(delta) against the uniform draw, truncated Taylor series and four squarings
   function automatic bit passes(longint signed delta, longint unsigned u);
      longint unsigned a, t, term, p;
      longint signed   sum;
      if (delta >= 0) return 1;
      a = longint'(-delta);
      if (a >= (64'd16 << FRAC)) return 0;
      t    = (a << 30) >> (FRAC + 4);
      sum  = longint'(QONE);
      term = QONE;
      for (int k = 1; k < TERMS; k++) begin
         term = ((term * t) >> 30) / longint'(k);
         if (k & 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(QONE)) sum = longint'(QONE);
      p = longint'(sum);
      for (int k = 0; k < 4; k++) p = (p * p) >> 30;
      return p > (u << 14);
   endfunction

   function void write_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == mres_pkg::CSR_WELL_GAIN) begin
         well_g = val[5:0];
         if (primed) cur_energy = well_energy(cur_pos, well_g);
      end else if (idx == mres_pkg::CSR_PARTNER_GAIN) begin
         partner_g = val[5:0];
      end else if (idx == mres_pkg::CSR_START_SAMPLE) begin
         start_pos = longint'($signed(val));
      end
   endfunction

   function void note(mres_pkg::req_type w);
      mres_pkg::rsp_type r;
      longint signed     noise, incoming, prop, delta, returned;
      longint unsigned   e_new, u;
      bit                ok;
      noise    = longint'($signed(w.step_noise));
      incoming = longint'($signed(w.partner_sample));
      u        = w.uniform_draw;
      returned = 0;
      if (!primed) begin
         cur_pos    = start_pos;
         cur_energy = well_energy(cur_pos, well_g);
         primed     = 1;
      end
      if (w.func == mres_pkg::FUNC_WALK) begin
         walks_in++;
         prop = cur_pos + noise;
         if (prop > SMAX) prop = SMAX;
         if (prop < SMIN) prop = SMIN;
         e_new = well_energy(prop, well_g);
         ok = passes(longint'(cur_energy) - longint'(e_new), u);
         if (ok) begin
            cur_pos    = prop;
            cur_energy = e_new;
            walk_cnt++;
         end
      end else begin
         swaps_in++;
         delta = longint'(well_energy(cur_pos, well_g))
               + longint'(well_energy(incoming, partner_g))
               - longint'(well_energy(incoming, well_g))
               - longint'(well_energy(cur_pos, partner_g));
         ok = passes(delta, u);
         if (ok) begin
            returned   = cur_pos;
            cur_pos    = incoming;
            cur_energy = well_energy(cur_pos, well_g);
            swap_cnt++;
         end else begin
            returned = incoming;
         end
      end
      r.sample_out      = cur_pos[23:0];
      r.energy_out      = cur_energy[37:0];
      r.move_accepted   = ok;
      r.returned_sample = returned[23:0];
      r.walk_accepts    = walk_cnt;
      r.swap_accepts    = swap_cnt;
      expected_q.push_back(r);
   endfunction

   function void check(mres_pkg::rsp_type got);
      mres_pkg::rsp_type want;
      words_seen++;
      if (expected_q.size() == 0) begin
         $error("result word with nothing expected");
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
         $error("sample_out expected %0h actual %0h", want.sample_out, got.sample_out);
         errors++;
      end
      if (got.energy_out !== want.energy_out) begin
         $error("energy_out expected %0h actual %0h", want.energy_out, got.energy_out);
         errors++;
      end
      if (got.move_accepted !== want.move_accepted) begin
         $error("move_accepted expected %0b actual %0b", want.move_accepted,
                got.move_accepted);
         errors++;
      end
      if (got.returned_sample !== want.returned_sample) begin
         $error("returned_sample expected %0h actual %0h", want.returned_sample,
                got.returned_sample);
         errors++;
      end
      if (got.walk_accepts !== want.walk_accepts) begin
         $error("walk_accepts expected %0d actual %0d", want.walk_accepts, got.walk_accepts);
         errors++;
      end
      if (got.swap_accepts !== want.swap_accepts) begin
         $error("swap_accepts expected %0d actual %0d", want.swap_accepts, got.swap_accepts);
         errors++;
      end
   endfunction
endclass

module testbench;
   import mres_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   // drain time after the last result, with margin for walks, exchanges and priming
   localparam int DRAIN_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   chain_scoreboard chain_sb = new();
   bit quiet = 1'b0;      // no idling on either side while set
   bit hold_off = 1'b0;   // ask the receiver for one long stall
   int unsigned long_stalls = 0;

   metropolis_replica_exchange_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10ns clock = ~clock;

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word and hold it until accepted, then note it for prediction.
   task automatic send_word(input req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      chain_sb.note(w);
   endtask

   // Write one register and mirror it at once; the block is idle here.
   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      chain_sb.write_reg(idx, val);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drop the offer and wait until every expected word is back, then let the
   // sequencer run out.
   task automatic settle();
      req_valid <= 1'b0;
      while (chain_sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_word(logic func, logic [23:0] noise, logic [15:0] draw,
                                         logic [23:0] partner);
      req_type w;
      w.func           = func;
      w.step_noise     = noise;
      w.uniform_draw   = draw;
      w.partner_sample = partner;
      return w;
   endfunction

   // Mostly small steps around the wells, sometimes the full range.
   function automatic req_type random_word();
      req_type     w;
      logic [23:0] full;
      logic [23:0] near;
      full = $urandom();
      w.func = ($urandom_range(0, 99) < 60) ? FUNC_WALK : FUNC_SWAP;
      if ($urandom_range(0, 99) < 20) w.step_noise = $urandom();
      else w.step_noise = $signed(full) >>> $urandom_range(3, 10);
      w.uniform_draw = $urandom();
      near = ($urandom_range(0, 1) ? 24'sh100000 : -24'sh100000)
             + ($signed(24'($urandom())) >>> $urandom_range(3, 9));
      w.partner_sample = ($urandom_range(0, 99) < 25) ? 24'($urandom()) : near;
      return w;
   endfunction

   // Receiver: random back-pressure, short and long stalls, one forced long hold.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset) chain_sb.check(rsp_data);
         if (hold_off) begin
            hold_off = 1'b0;
            stall = 2000;
            long_stalls++;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            stall = $urandom_range(20, 60);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   initial begin
      #(20ns * 3_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [23:0] max_s, min_s, one_s;
      max_s = 24'sh7FFFFF;
      min_s = 24'sh800000;
      one_s = 24'sh100000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start position is taken on the first word only
      csr_put(CSR_START_SAMPLE, 24'sh180000);
      csr_put(CSR_SPARE, 24'hFFFFFF);

      // directed: priming, range extremes, saturation, both operations
      send_word(make_word(FUNC_WALK, 24'd0, 16'd0, 24'd0));
      send_word(make_word(FUNC_WALK, max_s, 16'hFFFF, max_s));
      send_word(make_word(FUNC_WALK, max_s, 16'd0, min_s));
      send_word(make_word(FUNC_WALK, min_s, 16'd0, 24'd0));
      send_word(make_word(FUNC_WALK, min_s, 16'hFFFF, 24'd0));
      send_word(make_word(FUNC_WALK, 24'sh000400, 16'h8000, 24'd0));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'd0, max_s));
      send_word(make_word(FUNC_SWAP, max_s, 16'hFFFF, min_s));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'd0, one_s));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'hFFFF, -one_s));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'h0001, 24'd0));
      settle();
      // no effect after priming
      csr_put(CSR_START_SAMPLE, max_s);
      csr_put(CSR_WELL_GAIN, 24'd0);
      send_word(make_word(FUNC_WALK, 24'sh080000, 16'hFFFF, 24'd0));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'hFFFF, min_s));
      settle();
      csr_put(CSR_WELL_GAIN, 24'd63);
      csr_put(CSR_PARTNER_GAIN, 24'd0);
      send_word(make_word(FUNC_WALK, -24'sh010000, 16'h4000, 24'd0));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'd0, one_s));
      send_word(make_word(FUNC_SWAP, 24'd0, 16'hFFFF, 24'sh0C0000));
      settle();

      // random phases over several settings, extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_put(CSR_WELL_GAIN, 24'd1);
               csr_put(CSR_PARTNER_GAIN, 24'd21);
            end
            1: begin
               csr_put(CSR_WELL_GAIN, 24'd63);
               csr_put(CSR_PARTNER_GAIN, 24'd63);
            end
            2: begin
               csr_put(CSR_WELL_GAIN, 24'd0);
               csr_put(CSR_PARTNER_GAIN, 24'd63);
            end
            3: begin
               csr_put(CSR_WELL_GAIN, 24'd2);
               csr_put(CSR_PARTNER_GAIN, 24'd1);
               csr_put(CSR_SPARE, 24'd0);
            end
            default: begin
               csr_put(CSR_WELL_GAIN, 24'($urandom_range(0, 63)));
               csr_put(CSR_PARTNER_GAIN, 24'($urandom_range(0, 63)));
               csr_put(CSR_START_SAMPLE, 24'($urandom()));
            end
         endcase
         quiet = (ph == 4);
         // hold the receiver off while the sender keeps offering
         if (ph == 1) hold_off = 1'b1;
         repeat (125) send_word(random_word());
         settle();
      end
      quiet = 1'b0;

      $display("covered %0d walk and %0d exchange words, %0d results checked",
               chain_sb.walks_in, chain_sb.swaps_in, chain_sb.words_seen);
      $display("accepted walks %0d, accepted swaps %0d, long receiver holds %0d",
               chain_sb.walk_cnt, chain_sb.swap_cnt, long_stalls);
      if (chain_sb.errors == 0 && chain_sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire

FILE: sim.f
hdl/mres_pkg.sv
hdl/mres_mul.sv
hdl/metropolis_replica_exchange_step.sv
dv/testbench.sv
